// ===== rtl/quantized_fractional_delay_line_core_macros.svh =====
// Assertion macros used by the delay line RTL.
`ifndef QUANTIZED_FRACTIONAL_DELAY_LINE_CORE_MACROS_SVH
`define QUANTIZED_FRACTIONAL_DELAY_LINE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QFDL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QFDL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/qfdl_pkg.sv =====
// ----------------------------------------------------------------------------
// qfdl_pkg
// Types, codes and widths shared by the fractional delay line modules.
// ----------------------------------------------------------------------------
package qfdl_pkg;

    localparam int ADDR_W    = 16;
    localparam int DEPTH     = 65536;
    localparam int LEN_W     = 17;
    localparam int FRAC_W    = 16;
    localparam int DELAY_W   = 32;
    localparam int SMP_W     = 32;
    localparam int ACC_W     = 40;
    localparam int MULF_W    = FRAC_W + 1;
    localparam int PROD_W    = ACC_W + MULF_W;
    localparam int CRUSH_W   = 5;
    localparam int CRUSH_OFF = 24;
    localparam int MOD_W     = 17;
    localparam int MOD_CNT_W = 5;
    localparam int CMD_W     = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOOP_READ = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOOP_ADV  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRUSH  = 2'd2;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_WR_ENC, S_WR_MEM, S_ADV, S_CLR, S_SPAN,
        S_M_LB, S_L_POS, S_M_POS, S_M_DLY, S_R_POS, S_L_R, S_M_FIN,
        S_TA, S_TD, S_COEF, S_MUL, S_ACC, S_FINAL
    } t_state;

    typedef enum logic [1:0] {MA_LBEG, MA_POS, MA_DHI, MA_SUM} t_mod_a;
    typedef enum logic [1:0] {MD_LBM, MD_PM, MD_DMOD, MD_I0} t_mod_dst;

    typedef struct packed {
        logic     accept;
        logic     clr_en;
        logic     clr_all;
        logic     wr_enc;
        logic     wr_mem;
        logic     adv;
        logic     span_calc;
        logic     mod_go;
        t_mod_a   mod_a;
        logic     mod_span;
        t_mod_dst mod_dst;
        logic     plain_pos;
        logic     loop_pos;
        logic     loop_r;
        logic     tap_rd;
        logic     tap_cap;
        logic     coef;
        logic     mul;
        logic     acc_step;
        logic     final_ld;
    } t_ctrl;

    typedef struct packed {
        logic span_ok;
        logic loop;
        logic catmull;
        logic clr_last;
        logic mod_done;
        logic mod_busy;
        logic tap_last;
        logic step_last;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/qfdl_rem.sv =====
// ----------------------------------------------------------------------------
// qfdl_rem
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module qfdl_rem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  logic [qfdl_pkg::MOD_W-1:0] i_dividend,
    input  logic [qfdl_pkg::MOD_W-1:0] i_divisor,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [qfdl_pkg::MOD_W-1:0] o_rem
);

    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [qfdl_pkg::MOD_CNT_W-1:0] r_cnt, n_cnt;
    logic [qfdl_pkg::MOD_W-1:0]     r_num, n_num;
    logic [qfdl_pkg::MOD_W-1:0]     r_div, n_div;
    logic [qfdl_pkg::MOD_W-1:0]     r_rem, n_rem;
    logic [qfdl_pkg::MOD_W:0]       shifted;

    assign shifted = {r_rem, r_num[qfdl_pkg::MOD_W-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_div  = r_div;
        n_rem  = r_rem;
        if (r_busy) begin
            n_num = {r_num[qfdl_pkg::MOD_W-2:0], 1'b0};
            if (shifted >= {1'b0, r_div}) begin
                n_rem = qfdl_pkg::MOD_W'(shifted - {1'b0, r_div});
            end else begin
                n_rem = qfdl_pkg::MOD_W'(shifted);
            end
            if (r_cnt == qfdl_pkg::MOD_CNT_W'(qfdl_pkg::MOD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end else if (i_go && !r_done) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_num  = i_dividend;
            n_div  = i_divisor;
            n_rem  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/qfdl_datapath.sv =====
// ----------------------------------------------------------------------------
// qfdl_datapath
// Sample memory, position arithmetic, encoder, loader and interpolator.
// ----------------------------------------------------------------------------
module qfdl_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  qfdl_pkg::t_ctrl                i_ctrl,
    output qfdl_pkg::t_stat                o_stat,
    input  logic                           i_cfg_we,
    input  logic [qfdl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [qfdl_pkg::LEN_W-1:0]     i_cfg_data,
    input  logic [qfdl_pkg::CMD_W-1:0]     i_cmd,
    input  logic signed [qfdl_pkg::SMP_W-1:0] i_sample_in,
    input  logic [qfdl_pkg::DELAY_W-1:0]   i_delay,
    input  logic                           i_interp_mode,
    input  logic [qfdl_pkg::ADDR_W-1:0]    i_loop_begin,
    input  logic [qfdl_pkg::LEN_W-1:0]     i_loop_stop,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic signed [qfdl_pkg::SMP_W-1:0] o_read_value
);

    localparam int AW = qfdl_pkg::ADDR_W;
    localparam int LW = qfdl_pkg::LEN_W;
    localparam int FW = qfdl_pkg::FRAC_W;
    localparam int SW = qfdl_pkg::SMP_W;
    localparam int ACW = qfdl_pkg::ACC_W;
    localparam int PW = qfdl_pkg::PROD_W;
    localparam int POSW = LW + FW + 1;

    // Configuration.
    logic                          r_fmt;
    logic [LW-1:0]                 r_len_cfg;
    logic [qfdl_pkg::CRUSH_W-1:0]  r_crush;

    // Latched request.
    logic [qfdl_pkg::CMD_W-1:0] r_cmd;
    logic signed [SW-1:0]       r_sample;
    logic [qfdl_pkg::DELAY_W-1:0] r_delay;
    logic                       r_interp;
    logic [AW-1:0]              r_lbeg;
    logic [LW-1:0]              r_lstop;

    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_clr_idx;
    logic          r_loop;
    logic [LW-1:0] r_span;
    logic [AW-1:0] r_lbm, r_pos, r_pm, r_dmod, r_i0, r_frac;
    logic [LW-1:0] r_sum;
    logic [1:0]    r_tap;
    logic [1:0]    r_step;
    logic [SW-1:0] r_rdata;
    logic signed [SW-1:0] r_x [4];
    logic [30:0]   r_enc_mag;
    logic          r_enc_neg;
    logic signed [ACW-1:0] r_acc, r_d2, r_d1;
    logic signed [PW-1:0]  r_prod;
    logic          r_out_valid;
    logic signed [SW-1:0] r_read_value;

    logic [SW-1:0] mem [qfdl_pkg::DEPTH];

    logic [LW-1:0] len;
    logic [AW-1:0] wp_cur, wp_inc, len_m1;
    logic [LW-1:0] adv_p;
    logic signed [LW+1:0] span_s;
    logic [LW-1:0] mod_a, mod_m, mod_rem;
    logic          mod_busy, mod_done;
    logic [LW:0]   pos_sum;
    logic signed [POSW-1:0] plain_d, loop_d;
    logic [POSW-1:0] plain_r, loop_rr;
    logic [AW-1:0] i1, i2, im1, tap_addr;
    logic [AW:0]   i0p1, i1p1;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [SW-1:0] mem_wdata;
    logic [SW-1:0] enc_word;
    logic signed [SW-1:0] ld_val;
    logic [30:0]   clamp_mag, crush_mag, lsb_mask;
    logic [4:0]    crush_sh;
    logic          crush_on;
    logic signed [ACW-1:0] x0, x1, xm1, x2, mul_a, addend, y;
    logic signed [PW-1:0]  lin_sum;

    function automatic logic signed [ACW-1:0] rnd16(input logic signed [PW-1:0] v);
        logic [PW-1:0] mag;
        logic [PW-1:0] q;
        mag = v[PW-1] ? PW'(-v) : PW'(v);
        q   = (mag + (PW'(1) << (FW - 1))) >> FW;
        return v[PW-1] ? -ACW'(q) : ACW'(q);
    endfunction

    function automatic logic signed [ACW-1:0] rnd1(input logic signed [ACW-1:0] v);
        logic [ACW-1:0] mag;
        logic [ACW-1:0] q;
        mag = v[ACW-1] ? ACW'(-v) : ACW'(v);
        q   = (mag + ACW'(1)) >> 1;
        return v[ACW-1] ? -q : q;
    endfunction

    // A 16-bit code c stands for round(c * 2^30 / 32767). Since
    // 2^30 = 32767 * 32769 + 1, the quotient is mag * 32769 plus one
    // rounding bit.
    function automatic logic signed [SW-1:0] load_word(input logic [SW-1:0] w,
                                                       input logic fmt);
        logic [16:0] mag;
        logic [SW-1:0] v;
        mag = w[15] ? 17'(-{1'b1, w[15:0]}) : {1'b0, w[15:0]};
        v = SW'({mag, 15'd0}) + SW'(mag) + SW'((mag + 17'd16383) >= 17'd32767);
        if (fmt) begin
            return w;
        end
        return w[15] ? -v : v;
    endfunction

    // Effective length and write position.
    always_comb begin
        if (r_len_cfg == '0) begin
            len = LW'(1);
        end else if (r_len_cfg > LW'(qfdl_pkg::DEPTH)) begin
            len = LW'(qfdl_pkg::DEPTH);
        end else begin
            len = r_len_cfg;
        end
        len_m1 = AW'(len - 1'b1);
        wp_cur = ({1'b0, r_wp} < len) ? r_wp : '0;
        wp_inc = ((LW'(wp_cur) + 1'b1) >= len) ? '0 : wp_cur + 1'b1;
        adv_p  = LW'(wp_cur) + 1'b1;
        if (adv_p >= len) begin
            adv_p = '0;
        end
        if (adv_p == r_lstop) begin
            adv_p = (LW'(r_lbeg) < len) ? LW'(r_lbeg) : '0;
        end
    end

    // Loop span.
    always_comb begin
        if (r_lstop >= LW'(r_lbeg)) begin
            span_s = (LW+2)'(r_lstop) - (LW+2)'(r_lbeg);
        end else begin
            span_s = (LW+2)'(len) - ((LW+2)'(r_lbeg) - (LW+2)'(r_lstop));
        end
    end

    // Remainder unit operands.
    always_comb begin
        unique case (i_ctrl.mod_a)
            qfdl_pkg::MA_LBEG: mod_a = LW'(r_lbeg);
            qfdl_pkg::MA_POS:  mod_a = LW'(r_pos);
            qfdl_pkg::MA_DHI:  mod_a = LW'(r_delay[qfdl_pkg::DELAY_W-1:FW]);
            qfdl_pkg::MA_SUM:  mod_a = r_sum;
            default:           mod_a = r_sum;
        endcase
        mod_m = i_ctrl.mod_span ? r_span : len;
    end

    qfdl_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_ctrl.mod_go),
        .i_dividend (mod_a),
        .i_divisor  (mod_m),
        .o_busy     (mod_busy),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // Read positions behind the write position.
    always_comb begin
        pos_sum = (LW+1)'(wp_cur) + (LW+1)'(len) - (LW+1)'(r_lbm);
        if (pos_sum >= (LW+1)'(len)) begin
            pos_sum = pos_sum - (LW+1)'(len);
        end
        plain_d = POSW'({wp_cur, {FW{1'b0}}}) - POSW'({r_dmod, r_delay[FW-1:0]});
        plain_r = plain_d[POSW-1] ? POSW'(plain_d + POSW'({len, {FW{1'b0}}}))
                                  : POSW'(plain_d);
        loop_d  = POSW'({r_pm, {FW{1'b0}}}) - POSW'({r_dmod, r_delay[FW-1:0]});
        loop_rr = loop_d[POSW-1] ? POSW'(loop_d + POSW'({r_span, {FW{1'b0}}}))
                                 : POSW'(loop_d);
    end

    // Tap addresses, all wrapped to the length in use.
    always_comb begin
        i0p1 = (AW+1)'(r_i0) + 1'b1;
        i1   = (i0p1 == len) ? '0 : AW'(i0p1);
        i1p1 = (AW+1)'(i1) + 1'b1;
        i2   = (i1p1 == len) ? '0 : AW'(i1p1);
        im1  = (r_i0 == '0) ? len_m1 : r_i0 - 1'b1;
        unique case (r_tap)
            2'd0:    tap_addr = r_i0;
            2'd1:    tap_addr = i1;
            2'd2:    tap_addr = im1;
            default: tap_addr = i2;
        endcase
    end

    // Write encoder: clamp and bit-crush.
    always_comb begin
        if (r_sample > SW'(32'sd1073741824)) begin
            clamp_mag = 31'd1073741824;
        end else if (r_sample < -SW'(32'sd1073741824)) begin
            clamp_mag = 31'd1073741824;
        end else begin
            clamp_mag = r_sample[SW-1] ? 31'(-r_sample) : 31'(r_sample);
        end
        crush_on  = (r_crush != '0) && (r_crush < qfdl_pkg::CRUSH_W'(qfdl_pkg::CRUSH_OFF));
        crush_sh  = 5'd31 - r_crush;
        lsb_mask  = (31'd1 << crush_sh) - 31'd1;
        crush_mag = (clamp_mag + (lsb_mask >> 1) + 31'd1) & ~lsb_mask;
    end

    // Write encoder: storage format.
    always_comb begin
        logic [45:0] scaled;
        logic [15:0] code;
        scaled = {r_enc_mag, 15'd0} - 46'(r_enc_mag) + (46'd1 << 29);
        code   = scaled[45:30];
        if (r_fmt) begin
            enc_word = r_enc_neg ? -SW'(r_enc_mag) : SW'(r_enc_mag);
        end else begin
            enc_word = r_enc_neg ? -SW'(code) : SW'(code);
        end
    end

    assign mem_we    = i_ctrl.clr_en || i_ctrl.wr_mem;
    assign mem_waddr = i_ctrl.clr_en ? r_clr_idx : wp_cur;
    assign mem_wdata = i_ctrl.clr_en ? '0 : enc_word;
    assign ld_val    = load_word(r_rdata, r_fmt);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.tap_rd) begin
            r_rdata <= mem[tap_addr];
        end
    end

    // Interpolator.
    always_comb begin
        x0  = ACW'(r_x[0]);
        x1  = ACW'(r_x[1]);
        xm1 = ACW'(r_x[2]);
        x2  = ACW'(r_x[3]);
        mul_a = r_interp ? r_acc : x1 - x0;
        unique case (r_step)
            2'd0:    addend = r_d2;
            2'd1:    addend = r_d1;
            default: addend = x0 <<< 1;
        endcase
        lin_sum = r_prod + (PW'(x0) <<< FW);
        y = r_interp ? rnd1(r_acc) : r_acc;
    end

    // Configuration and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt       <= 1'b0;
            r_len_cfg   <= LW'(qfdl_pkg::DEPTH);
            r_crush     <= '0;
            r_wp        <= '0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            r_tap       <= '0;
            r_step      <= '0;
            r_loop      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    qfdl_pkg::REG_FORMAT: r_fmt     <= i_cfg_data[0];
                    qfdl_pkg::REG_LENGTH: r_len_cfg <= i_cfg_data;
                    qfdl_pkg::REG_CRUSH:  r_crush   <= i_cfg_data[qfdl_pkg::CRUSH_W-1:0];
                    default: ;
                endcase
            end
            if (i_ctrl.clr_en) begin
                r_clr_idx <= o_stat.clr_last ? '0 : r_clr_idx + 1'b1;
                if (!i_ctrl.clr_all) begin
                    r_wp <= '0;
                end
            end
            if (i_ctrl.wr_mem) begin
                r_wp <= wp_inc;
            end
            if (i_ctrl.adv) begin
                r_wp <= AW'(adv_p);
            end
            if (i_ctrl.accept) begin
                r_tap  <= '0;
                r_step <= '0;
            end
            if (i_ctrl.tap_cap) begin
                r_tap <= r_tap + 1'b1;
            end
            if (i_ctrl.acc_step) begin
                r_step <= r_step + 1'b1;
            end
            if (i_ctrl.span_calc) begin
                r_loop <= o_stat.span_ok;
            end
            if (i_ctrl.final_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_cmd    <= i_cmd;
            r_sample <= i_sample_in;
            r_delay  <= i_delay;
            r_interp <= i_interp_mode;
            r_lbeg   <= i_loop_begin;
            r_lstop  <= i_loop_stop;
        end
        if (i_ctrl.span_calc) begin
            r_span <= LW'(span_s);
        end
        if (i_ctrl.wr_enc) begin
            r_enc_mag <= crush_on ? crush_mag : clamp_mag;
            r_enc_neg <= r_sample[SW-1];
        end
        if (i_ctrl.mod_go && mod_done) begin
            unique case (i_ctrl.mod_dst)
                qfdl_pkg::MD_LBM:  r_lbm  <= AW'(mod_rem);
                qfdl_pkg::MD_PM:   r_pm   <= AW'(mod_rem);
                qfdl_pkg::MD_DMOD: r_dmod <= AW'(mod_rem);
                qfdl_pkg::MD_I0:   r_i0   <= AW'(mod_rem);
                default: ;
            endcase
        end
        if (i_ctrl.loop_pos) begin
            r_pos <= AW'(pos_sum);
        end
        if (i_ctrl.plain_pos) begin
            r_i0   <= AW'(plain_r >> FW);
            r_frac <= plain_r[FW-1:0];
        end
        if (i_ctrl.loop_r) begin
            r_sum  <= LW'(r_lbeg) + LW'(AW'(loop_rr >> FW));
            r_frac <= loop_rr[FW-1:0];
        end
        if (i_ctrl.tap_cap) begin
            r_x[r_tap] <= ld_val;
        end
        if (i_ctrl.coef) begin
            r_acc <= x2 - xm1 + (((x0 - x1) <<< 1) + (x0 - x1));
            r_d2  <= (xm1 <<< 1) - (x0 <<< 2) - x0 + (x1 <<< 2) - x2;
            r_d1  <= x1 - xm1;
        end
        if (i_ctrl.mul) begin
            r_prod <= PW'(mul_a) * PW'($signed({1'b0, r_frac}));
        end
        if (i_ctrl.acc_step) begin
            r_acc <= r_interp ? rnd16(r_prod) + addend : rnd16(lin_sum);
        end
        if (i_ctrl.final_ld) begin
            if (y > ACW'(64'sh7FFF_FFFF)) begin
                r_read_value <= 32'sh7FFF_FFFF;
            end else if (y < -ACW'(64'sh8000_0000)) begin
                r_read_value <= 32'sh8000_0000;
            end else begin
                r_read_value <= SW'(y);
            end
        end
    end

    assign o_stat.span_ok   = (r_cmd == qfdl_pkg::CMD_LOOP_READ) && (span_s > 0);
    assign o_stat.loop      = r_loop;
    assign o_stat.catmull   = r_interp;
    assign o_stat.clr_last  = r_clr_idx == (i_ctrl.clr_all ? AW'(qfdl_pkg::DEPTH - 1) : len_m1);
    assign o_stat.mod_done  = mod_done;
    assign o_stat.mod_busy  = mod_busy;
    assign o_stat.tap_last  = r_interp ? (r_tap == 2'd3) : (r_tap == 2'd1);
    assign o_stat.step_last = r_step == 2'd2;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;

endmodule

// ===== rtl/qfdl_ctrl.sv =====
// ----------------------------------------------------------------------------
// qfdl_ctrl
// Sequencer that steps the datapath through each request.
// ----------------------------------------------------------------------------
module qfdl_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [qfdl_pkg::CMD_W-1:0] i_cmd,
    input  qfdl_pkg::t_stat            i_stat,
    output qfdl_pkg::t_ctrl            o_ctrl,
    output logic                       o_in_ready
);

    qfdl_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qfdl_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            qfdl_pkg::S_INIT: begin
                if (i_stat.clr_last) n_state = qfdl_pkg::S_IDLE;
            end
            qfdl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_cmd)
                        qfdl_pkg::CMD_WRITE:     n_state = qfdl_pkg::S_WR_ENC;
                        qfdl_pkg::CMD_LOOP_ADV:  n_state = qfdl_pkg::S_ADV;
                        qfdl_pkg::CMD_CLEAR:     n_state = qfdl_pkg::S_CLR;
                        qfdl_pkg::CMD_READ:      n_state = qfdl_pkg::S_SPAN;
                        qfdl_pkg::CMD_LOOP_READ: n_state = qfdl_pkg::S_SPAN;
                        default:                 n_state = qfdl_pkg::S_IDLE;
                    endcase
                end
            end
            qfdl_pkg::S_WR_ENC: n_state = qfdl_pkg::S_WR_MEM;
            qfdl_pkg::S_WR_MEM: n_state = qfdl_pkg::S_IDLE;
            qfdl_pkg::S_ADV:    n_state = qfdl_pkg::S_IDLE;
            qfdl_pkg::S_CLR: begin
                if (i_stat.clr_last) n_state = qfdl_pkg::S_IDLE;
            end
            qfdl_pkg::S_SPAN: begin
                n_state = i_stat.span_ok ? qfdl_pkg::S_M_LB : qfdl_pkg::S_M_DLY;
            end
            qfdl_pkg::S_M_LB: begin
                if (i_stat.mod_done) n_state = qfdl_pkg::S_L_POS;
            end
            qfdl_pkg::S_L_POS: n_state = qfdl_pkg::S_M_POS;
            qfdl_pkg::S_M_POS: begin
                if (i_stat.mod_done) n_state = qfdl_pkg::S_M_DLY;
            end
            qfdl_pkg::S_M_DLY: begin
                if (i_stat.mod_done) begin
                    n_state = i_stat.loop ? qfdl_pkg::S_L_R : qfdl_pkg::S_R_POS;
                end
            end
            qfdl_pkg::S_R_POS: n_state = qfdl_pkg::S_TA;
            qfdl_pkg::S_L_R:   n_state = qfdl_pkg::S_M_FIN;
            qfdl_pkg::S_M_FIN: begin
                if (i_stat.mod_done) n_state = qfdl_pkg::S_TA;
            end
            qfdl_pkg::S_TA: n_state = qfdl_pkg::S_TD;
            qfdl_pkg::S_TD: begin
                if (!i_stat.tap_last) begin
                    n_state = qfdl_pkg::S_TA;
                end else begin
                    n_state = i_stat.catmull ? qfdl_pkg::S_COEF : qfdl_pkg::S_MUL;
                end
            end
            qfdl_pkg::S_COEF: n_state = qfdl_pkg::S_MUL;
            qfdl_pkg::S_MUL:  n_state = qfdl_pkg::S_ACC;
            qfdl_pkg::S_ACC: begin
                n_state = (i_stat.catmull && !i_stat.step_last) ? qfdl_pkg::S_MUL
                                                                : qfdl_pkg::S_FINAL;
            end
            qfdl_pkg::S_FINAL: begin
                if (i_stat.out_free) n_state = qfdl_pkg::S_IDLE;
            end
            default: n_state = qfdl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl         = '0;
        o_ctrl.mod_a   = qfdl_pkg::MA_LBEG;
        o_ctrl.mod_dst = qfdl_pkg::MD_LBM;
        o_in_ready     = 1'b0;
        unique case (r_state)
            qfdl_pkg::S_INIT: begin
                o_ctrl.clr_en  = 1'b1;
                o_ctrl.clr_all = 1'b1;
            end
            qfdl_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_ctrl.accept = i_in_valid;
            end
            qfdl_pkg::S_WR_ENC:  o_ctrl.wr_enc = 1'b1;
            qfdl_pkg::S_WR_MEM:  o_ctrl.wr_mem = 1'b1;
            qfdl_pkg::S_ADV:     o_ctrl.adv = 1'b1;
            qfdl_pkg::S_CLR:     o_ctrl.clr_en = 1'b1;
            qfdl_pkg::S_SPAN:    o_ctrl.span_calc = 1'b1;
            qfdl_pkg::S_M_LB: begin
                o_ctrl.mod_go  = 1'b1;
                o_ctrl.mod_a   = qfdl_pkg::MA_LBEG;
                o_ctrl.mod_dst = qfdl_pkg::MD_LBM;
            end
            qfdl_pkg::S_L_POS:   o_ctrl.loop_pos = 1'b1;
            qfdl_pkg::S_M_POS: begin
                o_ctrl.mod_go   = 1'b1;
                o_ctrl.mod_a    = qfdl_pkg::MA_POS;
                o_ctrl.mod_span = 1'b1;
                o_ctrl.mod_dst  = qfdl_pkg::MD_PM;
            end
            qfdl_pkg::S_M_DLY: begin
                o_ctrl.mod_go   = 1'b1;
                o_ctrl.mod_a    = qfdl_pkg::MA_DHI;
                o_ctrl.mod_span = i_stat.loop;
                o_ctrl.mod_dst  = qfdl_pkg::MD_DMOD;
            end
            qfdl_pkg::S_R_POS:   o_ctrl.plain_pos = 1'b1;
            qfdl_pkg::S_L_R:     o_ctrl.loop_r = 1'b1;
            qfdl_pkg::S_M_FIN: begin
                o_ctrl.mod_go  = 1'b1;
                o_ctrl.mod_a   = qfdl_pkg::MA_SUM;
                o_ctrl.mod_dst = qfdl_pkg::MD_I0;
            end
            qfdl_pkg::S_TA:      o_ctrl.tap_rd = 1'b1;
            qfdl_pkg::S_TD:      o_ctrl.tap_cap = 1'b1;
            qfdl_pkg::S_COEF:    o_ctrl.coef = 1'b1;
            qfdl_pkg::S_MUL:     o_ctrl.mul = 1'b1;
            qfdl_pkg::S_ACC:     o_ctrl.acc_step = 1'b1;
            qfdl_pkg::S_FINAL:   o_ctrl.final_ld = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

// ===== rtl/quantized_fractional_delay_line_core.sv =====
// ----------------------------------------------------------------------------
// quantized_fractional_delay_line_core
// Circular sample store with interpolated fractional-delay reads.
// ----------------------------------------------------------------------------
// Requests enter on i_in_valid/o_in_ready with a command and its operands;
// read and loop read requests return one interpolated sample on
// o_out_valid/i_out_ready, the other commands return nothing.
// One request is worked at a time. A write encodes the sample and then stores
// it; a loop advance moves the write position. A clear zeroes the entries of
// the length in use and resets the write position. In a read or loop read,
// each wrap of a position costs one pass of the bit-serial remainder unit,
// and the two (linear) or four (Catmull-Rom) taps come one at a time
// through the single memory read port.
// After reset the block sweeps all 65536 memory entries to zero, one per
// cycle, and holds o_in_ready low until that pass is over; configuration
// writes are taken at any time. The finished sample sits in an output
// register, so a new request is taken while it waits; a second result waits
// until the receiver has taken the first.
// ----------------------------------------------------------------------------
`include "quantized_fractional_delay_line_core_macros.svh"

module quantized_fractional_delay_line_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [qfdl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [qfdl_pkg::LEN_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [qfdl_pkg::CMD_W-1:0]        i_cmd,
    input  logic signed [qfdl_pkg::SMP_W-1:0] i_sample_in,
    input  logic [qfdl_pkg::DELAY_W-1:0]      i_delay,
    input  logic                              i_interp_mode,
    input  logic [qfdl_pkg::ADDR_W-1:0]       i_loop_begin,
    input  logic [qfdl_pkg::LEN_W-1:0]        i_loop_stop,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [qfdl_pkg::SMP_W-1:0] o_read_value
);

    qfdl_pkg::t_ctrl w_ctrl;
    qfdl_pkg::t_stat w_stat;

    qfdl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl),
        .o_in_ready (o_in_ready)
    );

    qfdl_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .o_stat        (w_stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (i_cmd),
        .i_sample_in   (i_sample_in),
        .i_delay       (i_delay),
        .i_interp_mode (i_interp_mode),
        .i_loop_begin  (i_loop_begin),
        .i_loop_stop   (i_loop_stop),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_read_value  (o_read_value)
    );

    `QFDL_ASSERT_SAME(a_ready_mod_idle, i_clk, i_rst_n, o_in_ready, !w_stat.mod_busy, "request taken while remainder unit busy")
    `QFDL_ASSERT_NEXT(a_write_no_result, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_cmd == qfdl_pkg::CMD_WRITE) && !o_out_valid, !o_out_valid, "write request produced a result")
    `QFDL_ASSERT_SAME(a_init_not_ready, i_clk, i_rst_n, !$past(i_rst_n), !o_in_ready, "request taken before memory sweep")

endmodule

// ===== verif/tb_quantized_fractional_delay_line_core.sv =====
// ----------------------------------------------------------------------------
// tb_quantized_fractional_delay_line_core
// Self-checking testbench for the fractional delay line core. A queue of
// requests feeds a bursty driver, and a predictor of the store, the write
// position and the interpolation computes each read result. The monitor
// stalls on its own pattern and compares every result in order. The run
// steps through several format, length and bit-crush settings.
// ----------------------------------------------------------------------------
module tb_quantized_fractional_delay_line_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [qfdl_pkg::CMD_W-1:0]        cmd;
        logic signed [qfdl_pkg::SMP_W-1:0] sample;
        logic [qfdl_pkg::DELAY_W-1:0]      delay;
        logic                              interp;
        logic [qfdl_pkg::ADDR_W-1:0]       lbeg;
        logic [qfdl_pkg::LEN_W-1:0]        lstop;
    } t_req;

    localparam longint ONE_Q30 = 64'sd1073741824;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [qfdl_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [qfdl_pkg::LEN_W-1:0]        cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              o_in_ready;
    logic [qfdl_pkg::CMD_W-1:0]        cmd_d = '0;
    logic signed [qfdl_pkg::SMP_W-1:0] sample_d = '0;
    logic [qfdl_pkg::DELAY_W-1:0]      delay_d = '0;
    logic                              interp_d = 1'b0;
    logic [qfdl_pkg::ADDR_W-1:0]       lbeg_d = '0;
    logic [qfdl_pkg::LEN_W-1:0]        lstop_d = '0;
    logic                              o_out_valid;
    logic                              out_ready = 1'b0;
    logic signed [qfdl_pkg::SMP_W-1:0] o_read_value;

    quantized_fractional_delay_line_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready),
        .i_cmd(cmd_d), .i_sample_in(sample_d), .i_delay(delay_d),
        .i_interp_mode(interp_d), .i_loop_begin(lbeg_d), .i_loop_stop(lstop_d),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready),
        .o_read_value(o_read_value)
    );

    always #1 i_clk = ~i_clk;

    // Shadow state of the block.
    int          sample_mem [qfdl_pkg::DEPTH];
    int unsigned wr_pos;
    logic        fmt_r;
    logic [16:0] len_r;
    logic [4:0]  crush_r;

    t_req                              pending_q[$];
    logic signed [qfdl_pkg::SMP_W-1:0] read_results_q[$];
    int n_fail = 0;
    int n_acc = 0;
    int n_writes = 0;
    int n_reads = 0;
    int n_loops = 0;
    int n_other = 0;
    int n_results = 0;

    function automatic int unsigned eff_len();
        if (len_r < 1) return 1;
        if (len_r > qfdl_pkg::DEPTH) return qfdl_pkg::DEPTH;
        return len_r;
    endfunction

    function automatic longint shr_round(longint v, int s);
        longint unsigned mag;
        mag = v < 0 ? longint'(-v) : v;
        mag = (mag + (64'd1 << (s - 1))) >> s;
        return v < 0 ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint load_tap(int unsigned idx);
        logic signed [15:0] c16;
        longint c, m;
        if (fmt_r == 1'b0) begin
            c16 = sample_mem[idx][15:0];
            c = c16;
            m = c < 0 ? -c : c;
            m = ((m << 30) + 16383) / 32767;
            return c < 0 ? -m : m;
        end
        return sample_mem[idx];
    endfunction

    function automatic void store_sample(int unsigned idx, longint x);
        longint q, mag;
        int s;
        if (x > ONE_Q30) x = ONE_Q30;
        if (x < -ONE_Q30) x = -ONE_Q30;
        if (crush_r > 0 && crush_r < qfdl_pkg::CRUSH_OFF) begin
            s = 31 - crush_r;
            q = shr_round(x, s);
            x = q < 0 ? -((-q) << s) : (q << s);
        end
        if (fmt_r == 1'b0) begin
            mag = x < 0 ? -x : x;
            mag = (mag * 32767 + (64'sd1 << 29)) >>> 30;
            sample_mem[idx] = int'(x < 0 ? -mag : mag);
        end else begin
            sample_mem[idx] = int'(x);
        end
    endfunction

    function automatic longint interpolate(longint unsigned pos_fx, logic interp,
                                           int unsigned len);
        longint unsigned r;
        int unsigned i0;
        longint f, x0, x1, xm1, x2, d3, d2, d1, t;
        r = pos_fx % (longint'(len) << qfdl_pkg::FRAC_W);
        i0 = int'(r >> qfdl_pkg::FRAC_W);
        f = longint'(r & 64'hFFFF);
        x0 = load_tap(i0);
        x1 = load_tap((i0 + 1) % len);
        if (!interp) return shr_round(x0 * 65536 + (x1 - x0) * f, qfdl_pkg::FRAC_W);
        xm1 = load_tap((i0 + len - 1) % len);
        x2 = load_tap((i0 + 2) % len);
        d3 = x2 - xm1 + 3 * (x0 - x1);
        d2 = 2 * xm1 - 5 * x0 + 4 * x1 - x2;
        d1 = x1 - xm1;
        t = shr_round(d3 * f, qfdl_pkg::FRAC_W) + d2;
        t = shr_round(t * f, qfdl_pkg::FRAC_W) + d1;
        t = shr_round(t * f, qfdl_pkg::FRAC_W) + 2 * x0;
        return shr_round(t, 1);
    endfunction

    function automatic longint unsigned behind(longint unsigned p, longint unsigned d,
                                               longint unsigned m);
        return (p % m + m - d % m) % m;
    endfunction

    // Applies one accepted request to the shadow state and queues any result.
    function automatic void apply_request(t_req rq);
        int unsigned len, wp, p, pos;
        longint span, y;
        longint unsigned len_fx, r;
        len = eff_len();
        wp = wr_pos < len ? wr_pos : 0;
        case (rq.cmd)
            qfdl_pkg::CMD_WRITE: begin
                store_sample(wp, longint'(rq.sample));
                wr_pos = (wp + 1 >= len) ? 0 : wp + 1;
                n_writes++;
            end
            qfdl_pkg::CMD_LOOP_ADV: begin
                p = wp + 1;
                if (p >= len) p = 0;
                if (p == rq.lstop) p = rq.lbeg < len ? rq.lbeg : 0;
                wr_pos = p;
                n_other++;
            end
            qfdl_pkg::CMD_CLEAR: begin
                for (int i = 0; i < len; i++) sample_mem[i] = 0;
                wr_pos = 0;
                n_other++;
            end
            qfdl_pkg::CMD_READ, qfdl_pkg::CMD_LOOP_READ: begin
                len_fx = longint'(len) << qfdl_pkg::FRAC_W;
                span = (rq.lstop >= rq.lbeg) ? longint'(rq.lstop) - longint'(rq.lbeg)
                                             : longint'(len) - (longint'(rq.lbeg)
                                               - longint'(rq.lstop));
                if (rq.cmd == qfdl_pkg::CMD_READ || span < 1) begin
                    y = interpolate(behind(longint'(wp) << qfdl_pkg::FRAC_W, rq.delay,
                                           len_fx), rq.interp, len);
                end else begin
                    pos = (wp + len - rq.lbeg % len) % len;
                    r = behind(longint'(pos) << qfdl_pkg::FRAC_W, rq.delay,
                               longint'(span) << qfdl_pkg::FRAC_W);
                    y = interpolate((longint'(rq.lbeg) << qfdl_pkg::FRAC_W) + r,
                                    rq.interp, len);
                end
                if (y > 64'sd2147483647) y = 64'sd2147483647;
                if (y < -64'sd2147483648) y = -64'sd2147483648;
                read_results_q.push_back(y[31:0]);
                if (rq.cmd == qfdl_pkg::CMD_READ) n_reads++;
                else n_loops++;
            end
            default: n_other++;
        endcase
    endfunction

    // Driver: bursts with random gaps, plus one pause until all results drain.
    int  gap_left = 0;
    int  burst_left = 5;
    bit  sync_hold = 0;
    t_req cur_req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                apply_request(cur_req);
                n_acc++;
                if (n_acc == 150) sync_hold = 1;
            end
            if (!in_valid || o_in_ready) begin
                if (sync_hold && read_results_q.size() != 0) begin
                    in_valid <= 1'b0;
                end else begin
                    sync_hold = 0;
                    if (gap_left > 0) begin
                        gap_left--;
                        in_valid <= 1'b0;
                    end else if (pending_q.size() > 0) begin
                        cur_req = pending_q.pop_front();
                        cmd_d <= cur_req.cmd;
                        sample_d <= cur_req.sample;
                        delay_d <= cur_req.delay;
                        interp_d <= cur_req.interp;
                        lbeg_d <= cur_req.lbeg;
                        lstop_d <= cur_req.lstop;
                        in_valid <= 1'b1;
                        if (burst_left > 0) begin
                            burst_left--;
                        end else begin
                            burst_left = $urandom_range(0, 20);
                            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                        end
                    end else begin
                        in_valid <= 1'b0;
                    end
                end
            end
        end
    end

    // Monitor: its own stall pattern and one long hold-off.
    int  hold_left = 0;
    bit  hold_done = 0;
    int  mode_left = 100;
    bit  stall_mode = 0;
    logic signed [qfdl_pkg::SMP_W-1:0] exp_val;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                n_results++;
                if (read_results_q.size() == 0) begin
                    $error("unexpected result read_value=%0d", o_read_value);
                    n_fail++;
                end else begin
                    exp_val = read_results_q.pop_front();
                    if (o_read_value !== exp_val) begin
                        $error("read_value mismatch: expected %0d, actual %0d",
                               exp_val, o_read_value);
                        n_fail++;
                    end
                end
                if (n_results == 40 && !hold_done) begin
                    hold_done = 1;
                    hold_left = 2000;
                end
            end
            if (mode_left > 0) begin
                mode_left--;
            end else begin
                mode_left = $urandom_range(50, 400);
                stall_mode = $urandom_range(0, 1);
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
            end
        end
    end

    function automatic t_req mk(logic [qfdl_pkg::CMD_W-1:0] c, int s, int unsigned d,
                                logic im, int unsigned lb, int unsigned ls);
        t_req r;
        r.cmd = c;
        r.sample = s;
        r.delay = d;
        r.interp = im;
        r.lbeg = lb[15:0];
        r.lstop = ls[16:0];
        return r;
    endfunction

    function automatic t_req random_request(int unsigned len);
        t_req r;
        int unsigned k, lim;
        k = $urandom_range(0, 99);
        if (k < 40) r.cmd = qfdl_pkg::CMD_WRITE;
        else if (k < 65) r.cmd = qfdl_pkg::CMD_READ;
        else if (k < 85) r.cmd = qfdl_pkg::CMD_LOOP_READ;
        else if (k < 92) r.cmd = qfdl_pkg::CMD_LOOP_ADV;
        else if (k < 95 && len <= 1024) r.cmd = qfdl_pkg::CMD_CLEAR;
        else if (k < 95) r.cmd = qfdl_pkg::CMD_WRITE;
        else r.cmd = 3'($urandom_range(5, 7));
        case ($urandom_range(0, 3))
            0: r.sample = $urandom;
            1: r.sample = $urandom_range(0, 2097152) - 1048576 + 1073741824;
            2: r.sample = -($urandom_range(0, 2097152) - 1048576 + 1073741824);
            default: r.sample = $urandom_range(0, 2147483647) - 1073741824;
        endcase
        // Keep the delay range inside 32 bits for the longest stores.
        lim = (len * 2 > 65535) ? 65535 : len * 2;
        r.delay = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, lim << 16);
        r.interp = $urandom_range(0, 1);
        if ($urandom_range(0, 4) == 0) begin
            r.lbeg = $urandom;
            r.lstop = $urandom;
        end else begin
            r.lbeg = $urandom_range(0, len - 1);
            r.lstop = $urandom_range(0, len);
        end
        return r;
    endfunction

    task automatic cfg_write(logic [qfdl_pkg::CFG_IDX_W-1:0] idx,
                             logic [qfdl_pkg::LEN_W-1:0] data);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            qfdl_pkg::REG_FORMAT: fmt_r = data[0];
            qfdl_pkg::REG_LENGTH: len_r = data;
            qfdl_pkg::REG_CRUSH:  crush_r = data[4:0];
            default: ;
        endcase
    endtask

    // Sampled on the falling edge so the driver's updates have settled.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_q.size() != 0 || in_valid || read_results_q.size() != 0);
        repeat (eff_len() + 200) @(posedge i_clk);
    endtask

    initial begin
        int fmts[8]   = '{0, 1, 0, 1, 0, 1, 0, 1};
        int lens[8]   = '{65536, 37, 4, 1, 256, 0, 131071, 1000};
        int crushs[8] = '{0, 8, 1, 23, 31, 24, 12, 0};
        for (int i = 0; i < qfdl_pkg::DEPTH; i++) sample_mem[i] = 0;
        wr_pos = 0;
        fmt_r = 1'b0;
        len_r = 17'd65536;
        crush_r = 5'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: clamping extremes, every command, loop corner cases.
        pending_q.push_back(mk(qfdl_pkg::CMD_WRITE, 32'h7FFFFFFF, 0, 0, 0, 0));
        pending_q.push_back(mk(qfdl_pkg::CMD_WRITE, 32'h80000000, 0, 0, 0, 0));
        pending_q.push_back(mk(qfdl_pkg::CMD_WRITE, 1073741824, 0, 0, 0, 0));
        pending_q.push_back(mk(qfdl_pkg::CMD_WRITE, -1073741824, 0, 0, 0, 0));
        pending_q.push_back(mk(qfdl_pkg::CMD_WRITE, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(qfdl_pkg::CMD_WRITE, 12345678, 0, 0, 0, 0));
        pending_q.push_back(mk(qfdl_pkg::CMD_READ, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(qfdl_pkg::CMD_READ, 0, 32'h00018000, 1, 0, 0));
        pending_q.push_back(mk(qfdl_pkg::CMD_READ, 0, 32'h00048000, 0, 0, 0));
        pending_q.push_back(mk(qfdl_pkg::CMD_READ, 0, 32'hFFFFFFFF, 1, 0, 0));
        pending_q.push_back(mk(qfdl_pkg::CMD_LOOP_READ, 0, 32'h00010000, 1, 3, 3));
        pending_q.push_back(mk(qfdl_pkg::CMD_LOOP_READ, 0, 32'h00028000, 1, 2, 5));
        pending_q.push_back(mk(qfdl_pkg::CMD_LOOP_READ, 0, 32'h00030001, 0, 65535, 3));
        pending_q.push_back(mk(qfdl_pkg::CMD_LOOP_READ, 0, 32'hFFFFFFFF, 1, 0, 65536));
        pending_q.push_back(mk(qfdl_pkg::CMD_LOOP_READ, 0, 32'h0000C000, 0, 10, 131071));
        pending_q.push_back(mk(qfdl_pkg::CMD_LOOP_ADV, 0, 0, 0, 1, 7));
        pending_q.push_back(mk(qfdl_pkg::CMD_LOOP_ADV, 0, 0, 0, 65535, 65536));
        pending_q.push_back(mk(3'd5, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(3'd6, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(3'd7, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(qfdl_pkg::CMD_READ, 0, 32'h00020000, 1, 0, 0));
        pending_q.push_back(mk(qfdl_pkg::CMD_CLEAR, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(qfdl_pkg::CMD_READ, 0, 32'h00030000, 1, 0, 0));

        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            cfg_write(qfdl_pkg::REG_FORMAT, fmts[ph]);
            cfg_write(qfdl_pkg::REG_LENGTH, lens[ph]);
            cfg_write(qfdl_pkg::REG_CRUSH, crushs[ph]);
            for (int n = 0; n < 50; n++) pending_q.push_back(random_request(eff_len()));
        end

        wait_idle();
        if (read_results_q.size() != 0) begin
            $error("%0d expected results never arrived", read_results_q.size());
            n_fail++;
        end
        $display("Ran %0d requests: %0d writes, %0d reads, %0d loop reads, %0d other.",
                 n_acc, n_writes, n_reads, n_loops, n_other);
        $display("Checked %0d results over 8 format, length and crush settings.", n_results);
        if (n_fail == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/qfdl_pkg.sv
rtl/qfdl_rem.sv
rtl/qfdl_datapath.sv
rtl/qfdl_ctrl.sv
rtl/quantized_fractional_delay_line_core.sv
verif/tb_quantized_fractional_delay_line_core.sv
